### hdl/dhld_pkg.sv
// Shared constants, types and codes for the decimal header length demux.
package dhld_pkg;

    // Table geometry
    localparam int MAX_FILES  = 128;
    localparam int IDX_W      = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int CUR_W      = $clog2(MAX_FILES + 1);
    localparam int SIZE_W     = 32;
    localparam int FNUM_W     = 7;
    localparam int COUNT_W    = 8;

    // Input queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CHAR_E    = 8'h45;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    // Stream phase codes
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    // Configuration register index
    localparam logic REG_FILE_COUNT = 1'b0;
    localparam int   PADDR_W        = 3;

    // One classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
    } t_item;

endpackage

### hdl/dhld_front.sv
// Front part: accepts stream bytes, tags size terminators and queues them.
module dhld_front
    import dhld_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  [7:0] i_data_byte,
    output logic  o_in_stall,
    output logic  o_item_valid,
    output t_item o_item,
    input  logic  i_item_pop
);

    t_item              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               push;
    logic               pop;
    t_item              item_in;

    // Stall on a full queue only
    assign o_in_stall   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push         = i_in_valid && !o_in_stall;
    assign o_item_valid = (r_count != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_queue[r_rd_ptr];

    // Classify the byte as a size terminator or not
    always_comb begin
        item_in.data   = i_data_byte;
        item_in.is_end = (i_data_byte == CHAR_E);
    end

    // Store the request
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= item_in;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

### hdl/dhld_back.sv
// Back part: parses sizes into the table, routes payload and skips empty files.
module dhld_back
    import dhld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CUR_W-1:0]  i_file_limit,
    input  logic              i_item_valid,
    input  t_item             i_item,
    output logic              o_item_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [FNUM_W-1:0] o_file_number,
    output logic [7:0]        o_payload_byte,
    output logic              o_last_of_file,
    output logic              o_all_done
);

    // Engine states
    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_SEEK_RD  = 2'd1;
    localparam logic [1:0] S_SEEK_CHK = 2'd2;
    localparam logic [1:0] S_EMIT     = 2'd3;

    logic [SIZE_W-1:0] r_table [MAX_FILES];
    logic [SIZE_W-1:0] r_rd_data;

    logic [1:0]        r_state,   n_state;
    logic [1:0]        r_phase,   n_phase;
    logic [SIZE_W-1:0] r_acc,     n_acc;
    logic [CUR_W-1:0]  r_cur,     n_cur;
    logic [SIZE_W-1:0] r_rem,     n_rem;
    logic              r_pend,    n_pend;
    logic [FNUM_W-1:0] r_p_file,  n_p_file;
    logic [7:0]        r_p_byte,  n_p_byte;
    logic              r_p_last,  n_p_last;
    logic              r_p_done,  n_p_done;

    logic              r_out_valid;
    logic [FNUM_W-1:0] r_out_file;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_done;

    logic              tbl_we;
    logic [CUR_W-1:0]  cur_inc;
    logic              slot_free;
    logic              load_out;

    assign cur_inc   = r_cur + CUR_W'(1);
    assign slot_free = !r_out_valid || !i_out_stall;

    // Engine next state
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_cur    = r_cur;
        n_rem    = r_rem;
        n_pend   = r_pend;
        n_p_file = r_p_file;
        n_p_byte = r_p_byte;
        n_p_last = r_p_last;
        n_p_done = r_p_done;
        o_item_pop = 1'b0;
        tbl_we     = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    if (r_phase == PH_HEADER) begin
                        if (i_item.is_end) begin
                            tbl_we = (r_cur < CUR_W'(MAX_FILES));
                            n_acc  = '0;
                            if (cur_inc >= i_file_limit) begin
                                n_cur   = '0;
                                n_pend  = 1'b0;
                                n_state = S_SEEK_RD;
                            end else begin
                                n_cur = cur_inc;
                            end
                        end else begin
                            // acc * 10 + byte - '0', wrapping at 32 bits
                            n_acc = {r_acc[SIZE_W-4:0], 3'b000}
                                  + {r_acc[SIZE_W-2:0], 1'b0}
                                  + {{(SIZE_W-8){1'b0}}, i_item.data}
                                  - {{(SIZE_W-8){1'b0}}, CHAR_ZERO};
                        end
                    end else if (r_phase == PH_PAYLOAD) begin
                        n_p_file = r_cur[FNUM_W-1:0];
                        n_p_byte = i_item.data;
                        n_rem    = r_rem - SIZE_W'(1);
                        if (r_rem == SIZE_W'(1)) begin
                            n_p_last = 1'b1;
                            n_cur    = cur_inc;
                            n_pend   = 1'b1;
                            n_state  = S_SEEK_RD;
                        end else begin
                            n_p_last = 1'b0;
                            n_p_done = 1'b0;
                            n_state  = S_EMIT;
                        end
                    end
                    // done phase: drop the request
                end
            end
            S_SEEK_RD: begin
                if (r_cur >= i_file_limit) begin
                    n_phase  = PH_DONE;
                    n_rem    = '0;
                    n_p_done = 1'b1;
                    n_state  = r_pend ? S_EMIT : S_IDLE;
                end else begin
                    n_state = S_SEEK_CHK;
                end
            end
            S_SEEK_CHK: begin
                if (r_rd_data == '0) begin
                    n_cur   = cur_inc;
                    n_state = S_SEEK_RD;
                end else begin
                    n_phase  = PH_PAYLOAD;
                    n_rem    = r_rd_data;
                    n_p_done = 1'b0;
                    n_state  = r_pend ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Size table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[r_cur[IDX_W-1:0]] <= r_acc;
        end
        r_rd_data <= r_table[r_cur[IDX_W-1:0]];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_HEADER;
            r_acc       <= '0;
            r_cur       <= '0;
            r_rem       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cur   <= n_cur;
            r_rem   <= n_rem;
            r_pend  <= n_pend;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pending result and output register payload
    always_ff @(posedge i_clk) begin
        r_p_file <= n_p_file;
        r_p_byte <= n_p_byte;
        r_p_last <= n_p_last;
        r_p_done <= n_p_done;
        if (load_out) begin
            r_out_file <= r_p_file;
            r_out_byte <= r_p_byte;
            r_out_last <= r_p_last;
            r_out_done <= r_p_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_file_number  = r_out_file;
    assign o_payload_byte = r_out_byte;
    assign o_last_of_file = r_out_last;
    assign o_all_done     = r_out_done;

endmodule

### hdl/decimal_header_length_demux.sv
// Top level: configuration port, front queue and back engine of the demux.
// A payload byte other than a file's last passes the front queue, the pending register
// and the output register before o_out_valid rises. Header bytes go back to back;
// a payload byte holds the engine until the output register is free, and a file's last
// byte or the header's final 'E' starts a seek for the next non-empty file.
// Reset (synchronous, active low) returns to the header phase with file_count 1.
module decimal_header_length_demux
    import dhld_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    input  logic [7:0]         i_data_byte,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FNUM_W-1:0]  o_file_number,
    output logic [7:0]         o_payload_byte,
    output logic               o_last_of_file,
    output logic               o_all_done
);

    logic [COUNT_W-1:0] r_file_count;
    logic [CUR_W-1:0]   file_limit;
    logic               item_valid;
    t_item              item;
    logic               item_pop;

    assign pready = 1'b1;

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_count <= COUNT_W'(1);
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_FILE_COUNT) begin
            r_file_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Register read
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_FILE_COUNT) begin
            prdata = {{(32-COUNT_W){1'b0}}, r_file_count};
        end
    end

    // Clamp the file count to 1..MAX_FILES
    always_comb begin
        if (r_file_count == '0) begin
            file_limit = CUR_W'(1);
        end else if (32'(r_file_count) > 32'(MAX_FILES)) begin
            file_limit = CUR_W'(MAX_FILES);
        end else begin
            file_limit = CUR_W'(r_file_count);
        end
    end

    dhld_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_data_byte  (i_data_byte),
        .o_in_stall   (o_in_stall),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    dhld_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_file_limit   (file_limit),
        .i_item_valid   (item_valid),
        .i_item         (item),
        .o_item_pop     (item_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_file_number  (o_file_number),
        .o_payload_byte (o_payload_byte),
        .o_last_of_file (o_last_of_file),
        .o_all_done     (o_all_done)
    );

endmodule
